[sv/fhcb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhcb_pkg: shared types and constants for the hit charge binning block
// grid size, field widths, register and command codes, controller links
// ----------------------------------------------------------------------------
package fhcb_pkg;

   // grid geometry
   localparam int WIRE_CELLS = 1024;
   localparam int TIME_CELLS = 512;
   localparam int CELL_DEPTH = WIRE_CELLS * TIME_CELLS;
   localparam int ADDR_W     = $clog2(CELL_DEPTH);
   localparam int IW         = $clog2(WIRE_CELLS);
   localparam int JW         = $clog2(TIME_CELLS);

   // divider: dividend covers the widest scaled coordinate (14 bits)
   localparam int QW         = 14;
   localparam int DIVISOR_W  = 7;
   localparam int STEP_W     = $clog2(QW + 1);

   localparam int SUM_W      = 32;
   localparam int CHARGE_W   = 24;

   // defaults in whole units, stored in sixteenths of a tick
   localparam int DEFAULT_TICK_MAX = 9600;
   localparam int DEFAULT_MAX_RMS  = 100;

   localparam logic [1:0]  PLANE_SELECT_RST = 2'd2;
   localparam logic [15:0] MAX_WIDTH_RST    = 16'(DEFAULT_MAX_RMS * 16);
   localparam logic [17:0] TICK_LOW_RST     = 18'd0;
   localparam logic [17:0] TICK_HIGH_RST    = 18'(DEFAULT_TICK_MAX * 16);
   localparam logic [15:0] WIRE_SCALE_RST   = 16'd19661;
   localparam logic [15:0] TIME_SCALE_RST   = 16'd3650;
   localparam logic [6:0]  CELL_SIZE_RST    = 7'd2;

   // register index codes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_SELECT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_LOW     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_HIGH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIRE_SCALE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_SCALE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE    = 3'd6;

   // item kind codes
   localparam logic [1:0] KIND_HIT   = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  view;
      logic [12:0] wire_req;
      logic [17:0] peak_time;
      logic [15:0] width;
      logic        fit_negative;
      logic [23:0] charge;
      logic [11:0] query_wire_cm;
      logic [11:0] query_time_cm;
   } req_type;

   typedef struct packed {
      logic [31:0] cell_total;
      logic        out_of_grid;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the accepted word
      logic prep;        // latch the time coordinate for the second division
      logic div_start;
      logic div_sel_j;   // divide the time coordinate
      logic take_i;
      logic take_j;      // latch cell address and grid flag
      logic wr_acc;      // write back accumulated sum
      logic take_total;  // latch read data for a query
      logic rsp_load;
      logic clr_start;
      logic clr_wr;      // zero one cell, advance sweep
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] in_kind;
      logic [1:0] word_kind;
      logic       hit_pass;
      logic       div_busy;
      logic       in_grid;
      logic       rsp_free;
      logic       clr_last;
   } status_type;

endpackage
`default_nettype wire

[sv/fhcb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhcb_ram: generic single-port-write, single-port-read memory
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fhcb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/fhcb_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhcb_div: restoring divider, one quotient bit per cycle
// quotient valid once busy drops after a start
// ----------------------------------------------------------------------------
module fhcb_div import fhcb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [QW-1:0]        dividend,
   input  wire logic [DIVISOR_W-1:0] divisor,
   output logic                      busy,
   output logic      [QW-1:0]        quotient
);

   logic [QW-1:0]        quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [DIVISOR_W:0]   rem_sh;
   logic [DIVISOR_W+1:0] diff;

   // shift in the next dividend bit, try a subtract
   assign rem_sh = {rem_ff, quo_ff[QW-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = STEP_W'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W+1]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIVISOR_W-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

[sv/fhcb_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhcb_dp: datapath of the hit charge binning block
// config registers, hit filter, scaling, divider, cell store, result register
// ----------------------------------------------------------------------------
module fhcb_dp import fhcb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_word,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire cmd_type               cmd,
   output status_type                 status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_word
);

   // config registers
   logic [1:0]  plane_select_ff, plane_select_in;
   logic [15:0] max_width_ff, max_width_in;
   logic [17:0] tick_low_ff, tick_low_in;
   logic [17:0] tick_high_ff, tick_high_in;
   logic [15:0] wire_scale_ff, wire_scale_in;
   logic [15:0] time_scale_ff, time_scale_in;
   logic [6:0]  cell_size_ff, cell_size_in;

   // item registers
   req_type           word_ff, word_in;
   logic [QW-1:0]     num_j_ff, num_j_in;
   logic [QW-1:0]     i_ff, i_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              grid_ff, grid_in;
   logic [SUM_W-1:0]  total_ff, total_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_word_ff, rsp_word_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic [28:0]          wire_prod;
   logic [33:0]          time_prod;
   logic [QW-1:0]        first_num;
   logic [QW-1:0]        div_dividend;
   logic [DIVISOR_W-1:0] edge_cm;
   logic                 div_busy;
   logic [QW-1:0]        div_quo;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [SUM_W-1:0]     ram_wdata;
   logic [SUM_W-1:0]     ram_rdata;
   logic [SUM_W:0]       sum_wide;
   logic [SUM_W-1:0]     sum_sat;
   logic                 hit_pass;

   always_comb begin
      plane_select_in = plane_select_ff;
      max_width_in    = max_width_ff;
      tick_low_in     = tick_low_ff;
      tick_high_in    = tick_high_ff;
      wire_scale_in   = wire_scale_ff;
      time_scale_in   = time_scale_ff;
      cell_size_in    = cell_size_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PLANE_SELECT: plane_select_in = csr_wdata[1:0];
            CSR_MAX_WIDTH:    max_width_in    = csr_wdata[15:0];
            CSR_TICK_LOW:     tick_low_in     = csr_wdata[17:0];
            CSR_TICK_HIGH:    tick_high_in    = csr_wdata[17:0];
            CSR_WIRE_SCALE:   wire_scale_in   = csr_wdata[15:0];
            CSR_TIME_SCALE:   time_scale_in   = csr_wdata[15:0];
            CSR_CELL_SIZE:    cell_size_in    = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // hit filter on the captured word
   assign hit_pass = (word_ff.view == plane_select_ff)
                   && (word_ff.width <= max_width_ff)
                   && !word_ff.fit_negative
                   && (word_ff.peak_time >= tick_low_ff)
                   && (word_ff.peak_time <= tick_high_ff);

   // scale to whole cm: wire * Q0.16, time * Q0.16 / 16
   assign wire_prod = 29'(word_ff.wire_req) * 29'(wire_scale_ff);
   assign time_prod = 34'(word_ff.peak_time) * 34'(time_scale_ff);

   assign first_num = (word_ff.kind == KIND_QUERY) ? QW'(word_ff.query_wire_cm)
                                                   : QW'(wire_prod[28:16]);
   assign div_dividend = cmd.div_sel_j ? num_j_ff : first_num;
   assign edge_cm = (cell_size_ff == '0) ? DIVISOR_W'(1) : cell_size_ff;

   fhcb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (edge_cm),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // saturating accumulate
   assign sum_wide = {1'b0, ram_rdata} + (SUM_W+1)'(word_ff.charge);
   assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

   assign ram_we    = cmd.clr_wr || cmd.wr_acc;
   assign ram_waddr = cmd.clr_wr ? clr_cnt_ff : addr_ff;
   assign ram_wdata = cmd.clr_wr ? '0 : sum_sat;

   fhcb_ram #(
      .WIDTH (SUM_W),
      .DEPTH (CELL_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      word_in      = word_ff;
      num_j_in     = num_j_ff;
      i_in         = i_ff;
      addr_in      = addr_ff;
      grid_in      = grid_ff;
      total_in     = total_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff;
      clr_cnt_in   = clr_cnt_ff;
      if (cmd.load) begin
         word_in = req_word;
      end
      if (cmd.prep) begin
         num_j_in = (word_ff.kind == KIND_QUERY) ? QW'(word_ff.query_time_cm)
                                                 : time_prod[33:20];
      end
      if (cmd.take_i) begin
         i_in = div_quo;
      end
      if (cmd.take_j) begin
         grid_in = (i_ff < QW'(WIRE_CELLS)) && (div_quo < QW'(TIME_CELLS));
         addr_in = ADDR_W'(i_ff[IW-1:0]) * ADDR_W'(TIME_CELLS)
                 + ADDR_W'(div_quo[JW-1:0]);
      end
      if (cmd.take_total) begin
         total_in = ram_rdata;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.cell_total  = grid_ff ? total_ff : '0;
         rsp_word_in.out_of_grid = !grid_ff;
      end
      if (cmd.clr_start) begin
         clr_cnt_in = '0;
      end else if (cmd.clr_wr) begin
         clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_select_ff <= PLANE_SELECT_RST;
         max_width_ff    <= MAX_WIDTH_RST;
         tick_low_ff     <= TICK_LOW_RST;
         tick_high_ff    <= TICK_HIGH_RST;
         wire_scale_ff   <= WIRE_SCALE_RST;
         time_scale_ff   <= TIME_SCALE_RST;
         cell_size_ff    <= CELL_SIZE_RST;
         rsp_valid_ff    <= 1'b0;
         clr_cnt_ff      <= '0;
      end else begin
         plane_select_ff <= plane_select_in;
         max_width_ff    <= max_width_in;
         tick_low_ff     <= tick_low_in;
         tick_high_ff    <= tick_high_in;
         wire_scale_ff   <= wire_scale_in;
         time_scale_ff   <= time_scale_in;
         cell_size_ff    <= cell_size_in;
         rsp_valid_ff    <= rsp_valid_in;
         clr_cnt_ff      <= clr_cnt_in;
      end
      word_ff     <= word_in;
      num_j_ff    <= num_j_in;
      i_ff        <= i_in;
      addr_ff     <= addr_in;
      grid_ff     <= grid_in;
      total_ff    <= total_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign status.in_kind   = req_word.kind;
   assign status.word_kind = word_ff.kind;
   assign status.hit_pass  = hit_pass;
   assign status.div_busy  = div_busy;
   assign status.in_grid   = grid_ff;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign status.clr_last  = (clr_cnt_ff == ADDR_W'(CELL_DEPTH - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

[sv/fhcb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhcb_ctrl: sequencer of the hit charge binning block
// steps one word through filter, division, cell read, result or write back
// ----------------------------------------------------------------------------
module fhcb_ctrl import fhcb_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PREP,
      S_DIV_I,
      S_DIV_J,
      S_READ,
      S_ACC,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               priority if (status.in_kind == KIND_HIT || status.in_kind == KIND_QUERY) begin
                  state_in = S_PREP;
               end else if (status.in_kind == KIND_CLEAR) begin
                  cmd.clr_start = 1'b1;
                  state_in      = S_CLEAR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PREP: begin
            if (status.word_kind == KIND_HIT && !status.hit_pass) begin
               state_in = S_IDLE;
            end else begin
               cmd.prep      = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_DIV_I;
            end
         end
         S_DIV_I: begin
            if (!status.div_busy) begin
               cmd.take_i    = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel_j = 1'b1;
               state_in      = S_DIV_J;
            end
         end
         S_DIV_J: begin
            if (!status.div_busy) begin
               cmd.take_j = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            if (status.in_grid) begin
               state_in = S_ACC;
            end else if (status.word_kind == KIND_QUERY) begin
               state_in = S_RESP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ACC: begin
            if (status.word_kind == KIND_QUERY) begin
               cmd.take_total = 1'b1;
               state_in       = S_RESP;
            end else begin
               cmd.wr_acc = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // divider is running the cycle after it was started
   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider not busy after start");

   // a result is only loaded when the output register can take it
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result loaded over a waiting word");

   // accumulate writes never land outside the grid
   a_wr_in_grid: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_acc |-> status.in_grid && status.word_kind == KIND_HIT)
      else $error("accumulate outside grid or for a non-hit");

   // no word is taken while the store is being zeroed
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_wr |-> !accept && !cmd.wr_acc)
      else $error("word accepted during clearing sweep");

endmodule
`default_nettype wire

[sv/filtered_hit_charge_binning.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// filtered_hit_charge_binning: 2d charge histogram of filtered detector hits
// hits add charge into a grid cell, queries read a cell, clear zeroes all of it
// ----------------------------------------------------------------------------
//
//   channel  | ports                        | moves
//   ---------+------------------------------+------------------------------
//   request  | req_valid, req_stall, req_word | hit, query or clear word
//   response | rsp_valid, rsp_stall, rsp_word | cell total for each query
//   config   | csr_we, csr_index, csr_wdata   | register write, no read-back
//
// a word is taken only once the previous one is through, req_stall is high
//   outside idle; one shared restoring divider turns each scaled coordinate
//   into a cell index, then one read of the cell store and a write back for
//   a hit; a dropped hit frees the input once the filter turns it away
// a query result goes into the response register once that is free
// a clear word, and reset, start a sweep that zeroes all 524288 cells of
//   the store, one a cycle; no word is taken meanwhile, csr writes still are
// a response word waits in its register while rsp_stall is high; the next
//   request word is taken meanwhile, a query only stalls at its own result
// reset is synchronous and active high
//
module filtered_hit_charge_binning import fhcb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request words
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_word,
   // response words
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_word,
   // register writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencer: owns the request handshake and the clearing sweep
   fhcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, divider, cell store and response register
   fhcb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire
